### rtl/core/sphc_pkg.sv
// Shared types, widths and a helper function for the sphere pair contact pipeline.
package sphc_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned LANES     = 2 * AXES;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] center_a_x;
    logic signed [31:0] center_a_y;
    logic signed [31:0] center_a_z;
    logic signed [31:0] center_b_x;
    logic signed [31:0] center_b_y;
    logic signed [31:0] center_b_z;
    logic        [30:0] radius_a;
    logic        [30:0] radius_b;
  } pair_in_t;

  typedef struct packed {
    logic               in_contact;
    logic signed [31:0] point_a_x;
    logic signed [31:0] point_a_y;
    logic signed [31:0] point_a_z;
    logic signed [31:0] point_b_x;
    logic signed [31:0] point_b_y;
    logic signed [31:0] point_b_z;
  } pair_out_t;

  // Data that rides alongside the square root.
  typedef struct packed {
    logic                   contact;
    logic [AXES-1:0]        neg;
    logic [AXES-1:0][31:0]  mag;
    logic [AXES-1:0][31:0]  ca;
    logic [AXES-1:0][31:0]  cb;
    logic [30:0]            ra;
    logic [30:0]            rb;
  } sq_side_t;

  // Data that rides alongside the dividers.
  typedef struct packed {
    logic                   contact;
    logic                   lzero;
    logic [AXES-1:0]        neg;
    logic [AXES-1:0][31:0]  ca;
    logic [AXES-1:0][31:0]  cb;
  } div_side_t;

  // Clamp a 33-bit signed value to the signed 32-bit range.
  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/sphc_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
module sphc_sqrt_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        radicand,
  input  sphc_pkg::sq_side_t in_side,
  output logic               out_valid,
  output logic [31:0]        root,
  output sphc_pkg::sq_side_t out_side
);
  import sphc_pkg::*;

  logic [SQ_STEPS:0] v;
  logic [63:0]       x     [SQ_STEPS+1];
  logic [33:0]       rem   [SQ_STEPS+1];
  logic [31:0]       rt    [SQ_STEPS+1];
  sq_side_t          side  [SQ_STEPS+1];

  assign v[0]    = in_valid;
  assign x[0]    = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
      rem_sh = {rem[k], x[k][63:62]};
      trial  = {2'b00, rt[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[k+1]    <= {x[k][61:0], 2'b00};
        rem[k+1]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        rt[k+1]   <= {rt[k][30:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[SQ_STEPS];
  assign root      = rt[SQ_STEPS];
  assign out_side  = side[SQ_STEPS];

endmodule

### rtl/core/sphc_div_pipe.sv
// Six parallel pipelined restoring dividers sharing one divisor, one quotient bit per stage.
module sphc_div_pipe (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [sphc_pkg::LANES-1:0][63:0]         num,
  input  logic [31:0]                              den,
  input  sphc_pkg::div_side_t                      in_side,
  output logic                                     out_valid,
  output logic [sphc_pkg::LANES-1:0][30:0]         quo,
  output sphc_pkg::div_side_t                      out_side
);
  import sphc_pkg::*;

  logic [DIV_STEPS:0]        v;
  logic [LANES-1:0][31:0]    rem  [DIV_STEPS+1];
  logic [LANES-1:0][30:0]    low  [DIV_STEPS+1];
  logic [LANES-1:0][30:0]    q    [DIV_STEPS+1];
  logic [31:0]               dv   [DIV_STEPS+1];
  div_side_t                 side [DIV_STEPS+1];

  assign v[0]    = in_valid;
  assign dv[0]   = den;
  assign side[0] = in_side;
  for (genvar l = 0; l < LANES; l++) begin : g_init
    // The quotient fits in 31 bits whenever the result is used, so the upper
    // part of the numerator already lies below the divisor.
    assign rem[0][l] = num[l][62:31];
    assign low[0][l] = num[l][30:0];
    assign q[0][l]   = '0;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [LANES-1:0][32:0] t;
    logic [LANES-1:0]       ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {rem[k][l], low[k][l][30]};
        ge[l] = t[l] >= {1'b0, dv[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k+1][l] <= ge[l] ? 32'(t[l] - {1'b0, dv[k]}) : t[l][31:0];
          low[k+1][l] <= {low[k][l][29:0], 1'b0};
          q[k+1][l]   <= {q[k][l][29:0], ge[l]};
        end
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[DIV_STEPS];
  assign quo       = q[DIV_STEPS];
  assign out_side  = side[DIV_STEPS];

endmodule

### rtl/core/sphere_pair_contact_points_top.sv
// Top level of the sphere pair contact pipeline: front end, square root, dividers, output.
//
//  Channel | Signals                      | Payload
//  --------+------------------------------+---------------------
//  in      | in_valid, in_stall, in_data  | sphc_pkg::pair_in_t
//  out     | out_valid, out_stall, out_data | sphc_pkg::pair_out_t
//
// One pair enters per cycle while in_stall is low; each result passes through the
// front end, the 32-stage square root, the 31-stage dividers and the output registers.
// Reset clears all valid bits; no item is in flight after it.
// A stalled output holds its result; the next finished result goes to a skid
// register, and only while that register is full does the whole pipe hold.
module sphere_pair_contact_points_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sphc_pkg::pair_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sphc_pkg::pair_out_t out_data
);
  import sphc_pkg::*;

  logic en;
  logic skid_v;
  pair_out_t skid;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  // Front end: differences, squares, squared distance and contact test.
  logic s1_v, s2_v, s3_v;
  sq_side_t s1_side, s2_side, s3_side;
  logic [AXES-1:0][32:0] s1_mag;
  logic [31:0] s1_sum;
  logic [AXES-1:0][64:0] s2_sq;
  logic [63:0] s2_s2;
  logic [63:0] s3_d2;

  logic [AXES-1:0][31:0] in_ca, in_cb;
  logic [AXES-1:0][32:0] in_d;
  logic [AXES-1:0][32:0] in_mag;
  logic [65:0] d2_full;

  always_comb begin
    in_ca = {in_data.center_a_z, in_data.center_a_y, in_data.center_a_x};
    in_cb = {in_data.center_b_z, in_data.center_b_y, in_data.center_b_x};
    for (int i = 0; i < AXES; i++) begin
      in_d[i]   = {in_ca[i][31], in_ca[i]} - {in_cb[i][31], in_cb[i]};
      in_mag[i] = in_d[i][32] ? 33'(-in_d[i]) : in_d[i];
    end
    d2_full = 66'(s2_sq[0]) + 66'(s2_sq[1]) + 66'(s2_sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.contact <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        s1_side.neg[i] <= in_d[i][32];
        s1_side.mag[i] <= in_mag[i][31:0];
        s1_mag[i]      <= in_mag[i];
      end
      s1_side.ca <= in_ca;
      s1_side.cb <= in_cb;
      s1_side.ra <= in_data.radius_a;
      s1_side.rb <= in_data.radius_b;
      s1_sum     <= {1'b0, in_data.radius_a} + {1'b0, in_data.radius_b};

      s2_side <= s1_side;
      for (int i = 0; i < AXES; i++) begin
        s2_sq[i] <= 65'(65'(s1_mag[i]) * 65'(s1_mag[i]));
      end
      s2_s2 <= 64'(s1_sum) * 64'(s1_sum);

      s3_side.contact <= d2_full < {2'b00, s2_s2};
      s3_side.neg     <= s2_side.neg;
      s3_side.mag     <= s2_side.mag;
      s3_side.ca      <= s2_side.ca;
      s3_side.cb      <= s2_side.cb;
      s3_side.ra      <= s2_side.ra;
      s3_side.rb      <= s2_side.rb;
      s3_d2           <= d2_full[63:0];
    end
  end

  // Distance.
  logic sq_v;
  logic [31:0] sq_root;
  sq_side_t sq_side;

  sphc_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_v),
    .radicand (s3_d2),
    .in_side  (s3_side),
    .out_valid(sq_v),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // Numerators: |d| * r, then the rounding half of the divisor.
  logic s4_v, s5_v;
  logic [LANES-1:0][62:0] s4_prod;
  logic [31:0] s4_len, s5_len;
  div_side_t s4_side, s5_side;
  logic [LANES-1:0][63:0] s5_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (en) begin
      s4_v <= sq_v;
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s4_prod[i]        <= 63'(sq_side.mag[i]) * 63'(sq_side.ra);
        s4_prod[AXES + i] <= 63'(sq_side.mag[i]) * 63'(sq_side.rb);
      end
      s4_len          <= sq_root;
      s4_side.contact <= sq_side.contact;
      s4_side.lzero   <= sq_root == '0;
      s4_side.neg     <= sq_side.neg;
      s4_side.ca      <= sq_side.ca;
      s4_side.cb      <= sq_side.cb;

      for (int l = 0; l < LANES; l++) begin
        s5_num[l] <= {1'b0, s4_prod[l]} + 64'(s4_len[31:1]);
      end
      s5_len  <= s4_len;
      s5_side <= s4_side;
    end
  end

  // Quotients.
  logic dv_v;
  logic [LANES-1:0][30:0] dv_q;
  div_side_t dv_side;

  sphc_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s5_v),
    .num      (s5_num),
    .den      (s5_len),
    .in_side  (s5_side),
    .out_valid(dv_v),
    .quo      (dv_q),
    .out_side (dv_side)
  );

  // Apply offsets, saturate and zero the points when there is no contact.
  logic pv;
  pair_out_t pd;
  logic [AXES-1:0][31:0] pa, pb;

  always_comb begin
    logic [32:0] qa, qb, ca33, cb33, va, vb;
    for (int i = 0; i < AXES; i++) begin
      qa   = dv_side.lzero ? '0 : 33'(dv_q[i]);
      qb   = dv_side.lzero ? '0 : 33'(dv_q[AXES + i]);
      ca33 = {dv_side.ca[i][31], dv_side.ca[i]};
      cb33 = {dv_side.cb[i][31], dv_side.cb[i]};
      va   = dv_side.neg[i] ? ca33 + qa : ca33 - qa;
      vb   = dv_side.neg[i] ? cb33 - qb : cb33 + qb;
      pa[i] = dv_side.contact ? sat33(va) : '0;
      pb[i] = dv_side.contact ? sat33(vb) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd.in_contact <= dv_side.contact;
      pd.point_a_x  <= pa[0];
      pd.point_a_y  <= pa[1];
      pd.point_a_z  <= pa[2];
      pd.point_b_x  <= pb[0];
      pd.point_b_y  <= pb[1];
      pd.point_b_z  <= pb[2];
    end
  end

  // Output register with skid stage.
  logic pd_push;
  assign pd_push = pv && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= pd_push;
      end
    end else if (pd_push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_v ? skid : pd;
    end else if (pd_push) begin
      skid <= pd;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid register full while output register is empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && pv && !skid_v) |=> skid_v)
    else $error("finished result lost while output was stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !out_stall) |=> (!skid_v && out_valid))
    else $error("skid register did not drain into output");

  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.in_contact) |->
      (out_data.point_a_x == '0 && out_data.point_a_y == '0 &&
       out_data.point_a_z == '0 && out_data.point_b_x == '0 &&
       out_data.point_b_y == '0 && out_data.point_b_z == '0))
    else $error("points not zero for a pair without contact");

endmodule
